@@ hdl/aot_pkg.sv @@
// ----------------------------------------------------------------------------
// aot_pkg: shared types for the box overlap table
// Operation codes, result kinds and sequencer states.
// ----------------------------------------------------------------------------
package aot_pkg;

    typedef enum logic [1:0] {
        MODE_REG   = 2'd0,
        MODE_UNREG = 2'd1,
        MODE_SET   = 2'd2,
        MODE_SCAN  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        KIND_ASSIGNED = 3'd0,
        KIND_MOVED    = 3'd1,
        KIND_DONE     = 3'd2,
        KIND_HIT      = 3'd3,
        KIND_NONE     = 3'd4,
        KIND_ERROR    = 3'd5
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_EDRD,
        S_EDIT,
        S_PRD,
        S_PTST,
        S_EMRD,
        S_EMTS,
        S_FIN
    } t_state;

    // A scan reports at most this many colliding boxes.
    localparam int RESULT_CAP = 64;
    localparam int NRES_W     = 7;
    localparam int SLOT_W     = 6;
    localparam int ENT_W      = 16;

endpackage

@@ hdl/aabb_overlap_table_top.sv @@
// ----------------------------------------------------------------------------
// aabb_overlap_table_top: table of axis-aligned boxes with pairwise overlap scan
// Register, unregister and set-owner edits on a box memory, and a scan that
// tests every box pair with one shared overlap unit and reports hit owners.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_mode i_slot i_entity_id i_pos_* i_size_*
//  result    out        o_valid / i_stall    o_kind o_out_slot o_out_entity o_last
//
//  Unregister and set owner read the box in S_EDRD and edit it in S_EDIT; an
//  out-of-range slot skips both. The single overlap unit tests the box pairs
//  one at a time, each pair read in S_PRD and tested in S_PTST.
//  Reset is synchronous and active low; it empties the table at once.
//  A result waiting under i_stall holds the sequencer only when it has a
//  further result to hand over.
// ----------------------------------------------------------------------------
module aabb_overlap_table_top #(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_mode,
    input  logic [aot_pkg::SLOT_W-1:0]          i_slot,
    input  logic [aot_pkg::ENT_W-1:0]           i_entity_id,
    input  logic signed [COORD_BITS-1:0]        i_pos_x,
    input  logic signed [COORD_BITS-1:0]        i_pos_y,
    input  logic [COORD_BITS-2:0]               i_size_x,
    input  logic [COORD_BITS-2:0]               i_size_y,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [2:0]                          o_kind,
    output logic [aot_pkg::SLOT_W-1:0]          o_out_slot,
    output logic [aot_pkg::ENT_W-1:0]           o_out_entity,
    output logic                                o_last
);

    localparam int C    = COORD_BITS;
    localparam int IW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW   = $clog2(MAX_BOXES + 1);
    localparam int CMPW = (CW > aot_pkg::SLOT_W) ? CW : aot_pkg::SLOT_W;
    localparam int EW   = aot_pkg::ENT_W;
    localparam int WW   = 2 * C + 2 * (C - 1) + EW;
    // Word layout: {x, y, w, h, owner}
    localparam int H_LO = EW;
    localparam int W_LO = H_LO + C - 1;
    localparam int Y_LO = W_LO + C - 1;
    localparam int X_LO = Y_LO + C;

    aot_pkg::t_state r_state, n_state;
    aot_pkg::t_mode  r_mode;

    logic [aot_pkg::SLOT_W-1:0] r_slot;
    logic [EW-1:0]              r_ent;
    logic [C-1:0]               r_px, r_py;
    logic [C-2:0]               r_sx, r_sy;

    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_i, n_i;
    logic [CW-1:0]        r_j, n_j;
    logic [MAX_BOXES-1:0] r_marks, n_marks;
    logic                 r_mark_a;
    logic [aot_pkg::NRES_W-1:0] r_nres, n_nres;

    logic                       r_pend_valid, n_pend_valid;
    logic [aot_pkg::SLOT_W-1:0] r_pend_slot, n_pend_slot;
    logic [EW-1:0]              r_pend_ent, n_pend_ent;

    logic                       r_o_valid;
    aot_pkg::t_kind             r_o_kind;
    logic [aot_pkg::SLOT_W-1:0] r_o_slot;
    logic [EW-1:0]              r_o_ent;
    logic                       r_o_last;

    logic [WW-1:0] r_mem [MAX_BOXES];
    logic [WW-1:0] r_rd_a, r_rd_b;

    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [WW-1:0] mem_wd;

    logic                       emit;
    aot_pkg::t_kind             e_kind;
    logic [aot_pkg::SLOT_W-1:0] e_slot;
    logic [EW-1:0]              e_ent;
    logic                       e_last;

    logic            out_free;
    logic            full;
    logic            slot_bad;
    logic [CMPW-1:0] slot_ext;
    logic [CMPW-1:0] cnt_ext;
    logic [CMPW-1:0] i_ext;
    logic [CW-1:0]   cnt_m1;
    logic            j_more;
    logic            i_more;
    logic            hit;
    logic            overlap;

    logic signed [C:0] ax, ax_end, ay, ay_end;
    logic signed [C:0] bx, bx_end, by, by_end;

    assign out_free = !r_o_valid || !i_stall;
    assign full     = (r_count == CW'(MAX_BOXES));
    assign slot_ext = CMPW'(r_slot);
    assign cnt_ext  = CMPW'(r_count);
    assign i_ext    = CMPW'(r_i);
    assign slot_bad = (slot_ext >= cnt_ext);
    assign cnt_m1   = r_count - CW'(1);
    assign j_more   = ({1'b0, r_j} + (CW + 1)'(1)) < {1'b0, r_count};
    assign i_more   = ({1'b0, r_i} + (CW + 1)'(2)) < {1'b0, r_count};
    assign hit      = r_mark_a &&
                      (r_nres < aot_pkg::NRES_W'(aot_pkg::RESULT_CAP));

    // Shared overlap unit. Edges that touch count as overlap; the test is
    // symmetric, so one evaluation covers both orders of the pair.
    always_comb begin
        ax     = {r_rd_a[X_LO+C-1], r_rd_a[X_LO +: C]};
        ay     = {r_rd_a[Y_LO+C-1], r_rd_a[Y_LO +: C]};
        bx     = {r_rd_b[X_LO+C-1], r_rd_b[X_LO +: C]};
        by     = {r_rd_b[Y_LO+C-1], r_rd_b[Y_LO +: C]};
        ax_end = ax + $signed({2'b00, r_rd_a[W_LO +: C-1]});
        ay_end = ay + $signed({2'b00, r_rd_a[H_LO +: C-1]});
        bx_end = bx + $signed({2'b00, r_rd_b[W_LO +: C-1]});
        by_end = by + $signed({2'b00, r_rd_b[H_LO +: C-1]});
        overlap = !(ax > bx_end) && !(ax_end < bx) && !(ay > by_end) && !(ay_end < by);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            aot_pkg::S_IDLE: begin
                if (i_valid) n_state = aot_pkg::S_EXEC;
            end
            aot_pkg::S_EXEC: begin
                unique case (r_mode)
                    aot_pkg::MODE_REG: begin
                        if (out_free) n_state = aot_pkg::S_IDLE;
                    end
                    aot_pkg::MODE_UNREG, aot_pkg::MODE_SET: begin
                        if (!slot_bad) n_state = aot_pkg::S_EDRD;
                        else if (out_free) n_state = aot_pkg::S_IDLE;
                    end
                    aot_pkg::MODE_SCAN: begin
                        if (r_count < CW'(2)) n_state = aot_pkg::S_EMRD;
                        else n_state = aot_pkg::S_PRD;
                    end
                    default: n_state = aot_pkg::S_IDLE;
                endcase
            end
            aot_pkg::S_EDRD: n_state = aot_pkg::S_EDIT;
            aot_pkg::S_EDIT: begin
                if (out_free) n_state = aot_pkg::S_IDLE;
            end
            aot_pkg::S_PRD:  n_state = aot_pkg::S_PTST;
            aot_pkg::S_PTST: begin
                if (j_more || i_more) n_state = aot_pkg::S_PRD;
                else n_state = aot_pkg::S_EMRD;
            end
            aot_pkg::S_EMRD: begin
                if (r_i >= r_count) n_state = aot_pkg::S_FIN;
                else n_state = aot_pkg::S_EMTS;
            end
            aot_pkg::S_EMTS: begin
                if (!(hit && r_pend_valid && !out_free)) n_state = aot_pkg::S_EMRD;
            end
            aot_pkg::S_FIN: begin
                if (out_free) n_state = aot_pkg::S_IDLE;
            end
            default: n_state = aot_pkg::S_IDLE;
        endcase
    end

    // Datapath actions and results.
    always_comb begin
        n_count      = r_count;
        n_i          = r_i;
        n_j          = r_j;
        n_marks      = r_marks;
        n_nres       = r_nres;
        n_pend_valid = r_pend_valid;
        n_pend_slot  = r_pend_slot;
        n_pend_ent   = r_pend_ent;
        mem_we       = 1'b0;
        mem_wa       = slot_ext[IW-1:0];
        mem_wd       = r_rd_a;
        emit         = 1'b0;
        e_kind       = aot_pkg::KIND_DONE;
        e_slot       = '0;
        e_ent        = '0;
        e_last       = 1'b1;
        unique case (r_state)
            aot_pkg::S_EXEC: begin
                unique case (r_mode)
                    aot_pkg::MODE_REG: begin
                        if (out_free) begin
                            emit = 1'b1;
                            if (full) begin
                                e_kind = aot_pkg::KIND_ERROR;
                            end else begin
                                e_kind  = aot_pkg::KIND_ASSIGNED;
                                e_slot  = cnt_ext[aot_pkg::SLOT_W-1:0];
                                mem_we  = 1'b1;
                                mem_wa  = r_count[IW-1:0];
                                mem_wd  = {r_px, r_py, r_sx, r_sy, r_ent};
                                n_count = r_count + CW'(1);
                            end
                        end
                    end
                    aot_pkg::MODE_UNREG, aot_pkg::MODE_SET: begin
                        if (slot_bad) begin
                            if (out_free) begin
                                emit   = 1'b1;
                                e_kind = aot_pkg::KIND_ERROR;
                            end
                        end else if (r_mode == aot_pkg::MODE_SET) begin
                            n_i = slot_ext[CW-1:0];
                        end else begin
                            n_i = cnt_m1;
                        end
                    end
                    aot_pkg::MODE_SCAN: begin
                        n_i    = '0;
                        n_j    = CW'(1);
                        n_nres = '0;
                    end
                    default: ;
                endcase
            end
            aot_pkg::S_EDIT: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (r_mode == aot_pkg::MODE_SET) begin
                        mem_we = 1'b1;
                        mem_wd = {r_rd_a[WW-1:EW], r_ent};
                    end else begin
                        n_count = cnt_m1;
                        // Removing any slot but the last moves the last box into it.
                        if (slot_ext < CMPW'(cnt_m1)) begin
                            mem_we = 1'b1;
                            e_kind = aot_pkg::KIND_MOVED;
                            e_slot = r_slot;
                            e_ent  = r_rd_a[EW-1:0];
                        end
                    end
                end
            end
            aot_pkg::S_PTST: begin
                if (overlap) begin
                    n_marks[r_i[IW-1:0]] = 1'b1;
                    n_marks[r_j[IW-1:0]] = 1'b1;
                end
                if (j_more) begin
                    n_j = r_j + CW'(1);
                end else if (i_more) begin
                    n_i = r_i + CW'(1);
                    n_j = r_i + CW'(2);
                end else begin
                    n_i = '0;
                end
            end
            aot_pkg::S_EMTS: begin
                // A hit is held back one step so the final one can carry last.
                if (!(hit && r_pend_valid && !out_free)) begin
                    n_i = r_i + CW'(1);
                    // The walk visits every box, so it leaves all marks clear.
                    n_marks[r_i[IW-1:0]] = 1'b0;
                    if (hit) begin
                        if (r_pend_valid) begin
                            emit   = 1'b1;
                            e_kind = aot_pkg::KIND_HIT;
                            e_slot = r_pend_slot;
                            e_ent  = r_pend_ent;
                            e_last = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_slot  = i_ext[aot_pkg::SLOT_W-1:0];
                        n_pend_ent   = r_rd_a[EW-1:0];
                        n_nres       = r_nres + aot_pkg::NRES_W'(1);
                    end
                end
            end
            aot_pkg::S_FIN: begin
                if (out_free) begin
                    emit         = 1'b1;
                    n_pend_valid = 1'b0;
                    if (r_pend_valid) begin
                        e_kind = aot_pkg::KIND_HIT;
                        e_slot = r_pend_slot;
                        e_ent  = r_pend_ent;
                    end else begin
                        e_kind = aot_pkg::KIND_NONE;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= aot_pkg::S_IDLE;
            r_count      <= '0;
            r_marks      <= '0;
            r_pend_valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_marks      <= n_marks;
            r_pend_valid <= n_pend_valid;
            if (emit) r_o_valid <= 1'b1;
            else if (!i_stall) r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == aot_pkg::S_IDLE && i_valid) begin
            r_mode <= aot_pkg::t_mode'(i_mode);
            r_slot <= i_slot;
            r_ent  <= i_entity_id;
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
            r_sx   <= i_size_x;
            r_sy   <= i_size_y;
        end
        r_i         <= n_i;
        r_j         <= n_j;
        r_nres      <= n_nres;
        r_pend_slot <= n_pend_slot;
        r_pend_ent  <= n_pend_ent;
        if (emit) begin
            r_o_kind <= e_kind;
            r_o_slot <= e_slot;
            r_o_ent  <= e_ent;
            r_o_last <= e_last;
        end
    end

    // Box memory: one write port, two registered read ports. The hit mark of
    // the box at the first read address is registered alongside it.
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd_a   <= r_mem[r_i[IW-1:0]];
        r_rd_b   <= r_mem[r_j[IW-1:0]];
        r_mark_a <= r_marks[r_i[IW-1:0]];
    end

    assign o_stall      = (r_state != aot_pkg::S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_kind       = r_o_kind;
    assign o_out_slot   = r_o_slot;
    assign o_out_entity = r_o_ent;
    assign o_last       = r_o_last;

    // Marks are always clear between items.
    a_marks_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aot_pkg::S_IDLE) |-> (r_marks == '0))
        else $error("hit marks left set while idle");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_count} <= (CW + 1)'(MAX_BOXES)))
        else $error("box count beyond table depth");

    a_pend_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_state == aot_pkg::S_EMRD || r_state == aot_pkg::S_EMTS ||
                          r_state == aot_pkg::S_FIN))
        else $error("pending hit outside result phase");

    a_reg_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aot_pkg::S_EXEC && r_mode == aot_pkg::MODE_REG && !full && out_free)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("register did not advance box count");

endmodule

@@ test/aabb_overlap_table_top_test.sv @@
// ----------------------------------------------------------------------------
// aabb_overlap_table_top_test: self-checking bench for the box overlap table
// Drives register, unregister, set-owner and scan transactions, keeps its own
// copy of the box table to predict every result, and compares each result
// field by field under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module aabb_overlap_table_top_test;

    localparam int TABLE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int LONG_HOLD   = 400;

    typedef struct {
        aot_pkg::t_kind kind;
        logic [5:0]     slot;
        logic [15:0]    entity;
        logic           last;
    } t_box_result;

    // Predicts the results of the box table and checks what the block returns.
    class t_overlap_predictor;
        logic signed [15:0] x_lo [TABLE_DEPTH];
        logic signed [15:0] y_lo [TABLE_DEPTH];
        logic [14:0]        w_of [TABLE_DEPTH];
        logic [14:0]        h_of [TABLE_DEPTH];
        logic [15:0]        owner_of [TABLE_DEPTH];
        int                 box_total;
        int                 errors;
        t_box_result        awaited [$];

        function new();
            box_total = 0;
            errors    = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void expect_result(aot_pkg::t_kind k, logic [5:0] s, logic [15:0] e,
                                    logic l);
            t_box_result r;
            r.kind   = k;
            r.slot   = s;
            r.entity = e;
            r.last   = l;
            awaited = {awaited, r};
        endfunction

        // Touching edges count as overlap; the sums are one bit wider so they never wrap.
        function bit boxes_overlap(int a, int b);
            logic signed [16:0] ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
            ax0 = x_lo[a];
            ay0 = y_lo[a];
            bx0 = x_lo[b];
            by0 = y_lo[b];
            ax1 = ax0 + $signed({2'b00, w_of[a]});
            ay1 = ay0 + $signed({2'b00, h_of[a]});
            bx1 = bx0 + $signed({2'b00, w_of[b]});
            by1 = by0 + $signed({2'b00, h_of[b]});
            return !(ax0 > bx1 || ax1 < bx0 || ay0 > by1 || ay1 < by0);
        endfunction

        function void accept_item(aot_pkg::t_mode m, logic [5:0] s, logic [15:0] e,
                                  logic [15:0] px, logic [15:0] py,
                                  logic [14:0] sx, logic [14:0] sy);
            bit [TABLE_DEPTH-1:0] marked;
            int hits;
            int tail;
            case (m)
                aot_pkg::MODE_REG: begin
                    if (box_total >= TABLE_DEPTH) begin
                        expect_result(aot_pkg::KIND_ERROR, '0, '0, 1'b1);
                    end else begin
                        x_lo[box_total]     = px;
                        y_lo[box_total]     = py;
                        w_of[box_total]     = sx;
                        h_of[box_total]     = sy;
                        owner_of[box_total] = e;
                        expect_result(aot_pkg::KIND_ASSIGNED, 6'(box_total), '0, 1'b1);
                        box_total++;
                    end
                end
                aot_pkg::MODE_UNREG, aot_pkg::MODE_SET: begin
                    if (int'(s) >= box_total) begin
                        expect_result(aot_pkg::KIND_ERROR, '0, '0, 1'b1);
                    end else if (m == aot_pkg::MODE_SET) begin
                        owner_of[s] = e;
                        expect_result(aot_pkg::KIND_DONE, '0, '0, 1'b1);
                    end else begin
                        tail = box_total - 1;
                        box_total = tail;
                        if (int'(s) < tail) begin
                            // The last box fills the hole left by the removed one.
                            x_lo[s]     = x_lo[tail];
                            y_lo[s]     = y_lo[tail];
                            w_of[s]     = w_of[tail];
                            h_of[s]     = h_of[tail];
                            owner_of[s] = owner_of[tail];
                            expect_result(aot_pkg::KIND_MOVED, s, owner_of[s], 1'b1);
                        end else begin
                            expect_result(aot_pkg::KIND_DONE, '0, '0, 1'b1);
                        end
                    end
                end
                default: begin
                    marked = '0;
                    for (int i = 0; i < box_total; i++) begin
                        for (int j = i + 1; j < box_total; j++) begin
                            if (boxes_overlap(i, j)) begin
                                marked[i] = 1'b1;
                                marked[j] = 1'b1;
                            end
                        end
                    end
                    hits = 0;
                    for (int i = 0; i < box_total; i++) begin
                        if (marked[i] && hits < aot_pkg::RESULT_CAP) begin
                            expect_result(aot_pkg::KIND_HIT, 6'(i), owner_of[i], 1'b0);
                            hits++;
                        end
                    end
                    if (hits == 0) begin
                        expect_result(aot_pkg::KIND_NONE, '0, '0, 1'b1);
                    end else begin
                        awaited[awaited.size() - 1].last = 1'b1;
                    end
                end
            endcase
        endfunction

        task report(string what, int got, int want);
            $display("check: %s got %0h, expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(logic [2:0] k, logic [5:0] s, logic [15:0] e, logic l);
            t_box_result r;
            if (awaited.size() == 0) begin
                report("result with none outstanding, kind", int'(k), 0);
            end else begin
                r = awaited.pop_front();
                if (k !== r.kind) report("kind", int'(k), int'(r.kind));
                if (s !== r.slot) report("out_slot", int'(s), int'(r.slot));
                if (e !== r.entity) report("out_entity", int'(e), int'(r.entity));
                if (l !== r.last) report("last", int'(l), int'(r.last));
            end
        endtask
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic [1:0]                 i_mode;
    logic [aot_pkg::SLOT_W-1:0] i_slot;
    logic [aot_pkg::ENT_W-1:0]  i_entity_id;
    logic signed [15:0]         i_pos_x;
    logic signed [15:0]         i_pos_y;
    logic [14:0]                i_size_x;
    logic [14:0]                i_size_y;
    logic                       o_valid;
    logic                       i_stall;
    logic [2:0]                 o_kind;
    logic [aot_pkg::SLOT_W-1:0] o_out_slot;
    logic [aot_pkg::ENT_W-1:0]  o_out_entity;
    logic                       o_last;

    t_overlap_predictor table_model;
    int                 items_offered = 0;
    int                 cycle_count = 0;

    aabb_overlap_table_top i_dut (.*);

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            table_model.check_result(o_kind, o_out_slot, o_out_entity, o_last);
        end
    end

    // Result side: random stalls, quiet stretches, and one long hold-off.
    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (taken == 30) begin
                repeat (LONG_HOLD) begin
                    @(negedge i_clk);
                    i_stall <= 1'b1;
                end
            end else begin
                gap = (taken % 32 < 10) ? 0 : $urandom_range(0, 3);
                repeat (gap) begin
                    @(negedge i_clk);
                    i_stall <= 1'b1;
                end
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            taken++;
        end
    end

    task automatic offer(input aot_pkg::t_mode m, input logic [5:0] s,
                         input logic [15:0] e,
                         input logic [15:0] px, input logic [15:0] py,
                         input logic [14:0] sx, input logic [14:0] sy);
        int gap;
        gap = (items_offered % 24 < 8) ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_mode      <= m;
        i_slot      <= s;
        i_entity_id <= e;
        i_pos_x     <= px;
        i_pos_y     <= py;
        i_size_x    <= sx;
        i_size_y    <= sy;
        do @(posedge i_clk); while (o_stall);
        table_model.accept_item(m, s, e, px, py, sx, sy);
        items_offered++;
    endtask

    // Wide boxes span the whole coordinate range; the others crowd near the origin.
    task automatic add_box(input bit wide);
        logic [15:0] px, py;
        logic [14:0] sx, sy;
        if (wide) begin
            px = 16'($urandom);
            py = 16'($urandom);
            sx = 15'($urandom);
            sy = 15'($urandom);
        end else begin
            px = 16'($urandom_range(0, 4095)) - 16'd2048;
            py = 16'($urandom_range(0, 4095)) - 16'd2048;
            sx = 15'($urandom_range(0, 767));
            sy = 15'($urandom_range(0, 767));
        end
        offer(aot_pkg::MODE_REG, 6'($urandom), 16'($urandom), px, py, sx, sy);
    endtask

    task automatic edit_box(input aot_pkg::t_mode m);
        logic [5:0] s;
        if (table_model.box_total > 0 && $urandom_range(0, 99) < 85) begin
            s = 6'($urandom_range(0, table_model.box_total - 1));
        end else begin
            s = 6'($urandom);
        end
        offer(m, s, 16'($urandom), 16'($urandom), 16'($urandom),
              15'($urandom), 15'($urandom));
    endtask

    task automatic settle_table();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (table_model.pending() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int pick;
        table_model = new();
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_mode      = aot_pkg::MODE_REG;
        i_slot      = '0;
        i_entity_id = '0;
        i_pos_x     = '0;
        i_pos_y     = '0;
        i_size_x    = '0;
        i_size_y    = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table: scan with nothing, edits out of range.
        offer(aot_pkg::MODE_SCAN, 6'd0, 16'h0000, 16'h0000, 16'h0000, 15'h0000, 15'h0000);
        offer(aot_pkg::MODE_UNREG, 6'd0, 16'h0000, 16'h0000, 16'h0000, 15'h0000, 15'h0000);
        offer(aot_pkg::MODE_SET, 6'd0, 16'hffff, 16'h0000, 16'h0000, 15'h0000, 15'h0000);
        // Opposite corners of the coordinate space do not meet.
        offer(aot_pkg::MODE_REG, 6'd0, 16'hffff, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff);
        offer(aot_pkg::MODE_REG, 6'd0, 16'h0000, 16'h7fff, 16'h7fff, 15'h0000, 15'h0000);
        offer(aot_pkg::MODE_SCAN, 6'd0, 16'h0000, 16'h0000, 16'h0000, 15'h0000, 15'h0000);
        // A point box exactly on the far corner of the first box touches it.
        offer(aot_pkg::MODE_REG, 6'd0, 16'h1234, 16'hffff, 16'hffff, 15'h0000, 15'h0000);
        offer(aot_pkg::MODE_SCAN, 6'd0, 16'h0000, 16'h0000, 16'h0000, 15'h0000, 15'h0000);
        offer(aot_pkg::MODE_SET, 6'd2, 16'habcd, 16'h0000, 16'h0000, 15'h0000, 15'h0000);
        offer(aot_pkg::MODE_SET, 6'd3, 16'h1111, 16'h0000, 16'h0000, 15'h0000, 15'h0000);
        offer(aot_pkg::MODE_UNREG, 6'd0, 16'h0000, 16'h0000, 16'h0000, 15'h0000, 15'h0000);
        offer(aot_pkg::MODE_UNREG, 6'd1, 16'h0000, 16'h0000, 16'h0000, 15'h0000, 15'h0000);
        offer(aot_pkg::MODE_UNREG, 6'd63, 16'h0000, 16'h0000, 16'h0000, 15'h0000, 15'h0000);
        // One unit apart on x: no overlap.
        offer(aot_pkg::MODE_REG, 6'd0, 16'h5a5a, 16'h0000, 16'hffff, 15'h0000, 15'h0000);
        offer(aot_pkg::MODE_REG, 6'd0, 16'h0f0f, 16'h2aaa, 16'h5555, 15'h5555, 15'h2aaa);
        offer(aot_pkg::MODE_SCAN, 6'd0, 16'h0000, 16'h0000, 16'h0000, 15'h0000, 15'h0000);
        // Edge sums beyond the coordinate width must not wrap.
        offer(aot_pkg::MODE_REG, 6'd0, 16'ha5a5, 16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff);
        offer(aot_pkg::MODE_SCAN, 6'd0, 16'h0000, 16'h0000, 16'h0000, 15'h0000, 15'h0000);
        offer(aot_pkg::MODE_SET, 6'd1, 16'h0000, 16'h0000, 16'h0000, 15'h0000, 15'h0000);
        offer(aot_pkg::MODE_UNREG, 6'd3, 16'h0000, 16'h0000, 16'h0000, 15'h0000, 15'h0000);
        settle_table();

        for (int n = 0; n < 40; n++) begin
            pick = $urandom_range(0, 99);
            if (table_model.box_total < 4 && pick >= 6) pick = 20;
            if (pick < 6) begin
                offer(aot_pkg::t_mode'($urandom_range(0, 3)), 6'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom));
            end else if (pick < 40) begin
                add_box($urandom_range(0, 99) < 25);
            end else if (pick < 58) begin
                edit_box(aot_pkg::MODE_UNREG);
            end else if (pick < 76) begin
                edit_box(aot_pkg::MODE_SET);
            end else begin
                offer(aot_pkg::MODE_SCAN, 6'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 15'($urandom), 15'($urandom));
            end
        end

        // Fill the table to capacity, overflow it, scan it, then thin it out.
        settle_table();
        while (table_model.box_total < TABLE_DEPTH) add_box($urandom_range(0, 1));
        add_box(1'b0);
        offer(aot_pkg::MODE_SCAN, 6'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 15'($urandom), 15'($urandom));
        offer(aot_pkg::MODE_SET, 6'd63, 16'($urandom), 16'h0000, 16'h0000, 15'h0000,
              15'h0000);
        offer(aot_pkg::MODE_UNREG, 6'd63, 16'h0000, 16'h0000, 16'h0000, 15'h0000, 15'h0000);
        add_box(1'b1);
        offer(aot_pkg::MODE_UNREG, 6'd0, 16'h0000, 16'h0000, 16'h0000, 15'h0000, 15'h0000);
        while (table_model.box_total > 40) edit_box(aot_pkg::MODE_UNREG);
        offer(aot_pkg::MODE_SCAN, 6'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 15'($urandom), 15'($urandom));

        settle_table();
        repeat (50) @(posedge i_clk);
        if (table_model.errors == 0 && table_model.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
